>>> rtl/vbt_pkg.sv
// package for the vario beep tone controller: constants, types and cadence helpers
package vbt_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int EVAL_MS       = 180;
    localparam int ENTER_SAMPLES = 4;
    localparam int RATE_CAP_MMS  = 8000;
    localparam int SINK_SLOPE    = 30;
    localparam int SINK_FLOOR    = 120;

    // register indexes
    localparam logic [2:0] REG_CLIMB_START = 3'd0;
    localparam logic [2:0] REG_CLIMB_STOP  = 3'd1;
    localparam logic [2:0] REG_SINK_START  = 3'd2;
    localparam logic [2:0] REG_SINK_STOP   = 3'd3;
    localparam logic [2:0] REG_CLIMB_BASE  = 3'd4;
    localparam logic [2:0] REG_CLIMB_GAIN  = 3'd5;
    localparam logic [2:0] REG_SINK_BASE   = 3'd6;
    localparam logic [2:0] REG_SINK_EN     = 3'd7;

    localparam logic [1:0] MODE_SILENT = 2'd0;
    localparam logic [1:0] MODE_CLIMB  = 2'd1;
    localparam logic [1:0] MODE_SINK   = 2'd2;

    // classified item handed from the front part to the back part
    typedef struct packed {
        logic [1:0]  mode;       // mode after this item
        logic        changed;    // mode differs from the one before
        logic [12:0] rate;       // clamped rate magnitude for the active mode
        logic [31:0] now;        // timestamp, full width, masked in the back part
    } item_t;

    // cadence segment data: knot rate, span, period, period delta, duty, duty delta
    // beyond an end knot the segment is flat with a span of 1000 and zero deltas
    typedef struct packed {
        logic [12:0]        r0;
        logic [12:0]        span;
        logic [9:0]         p0;
        logic signed [9:0]  dp;
        logic [6:0]         u0;
        logic signed [6:0]  du;
    } seg_t;

    function automatic seg_t climb_seg(input logic [12:0] r);
        seg_t s;
        s = '0;
        if (r == 13'd0) begin
            s.span = 13'd1000; s.p0 = 10'd550; s.u0 = 7'd20;
        end else if (r <= 13'd500) begin
            s.r0 = 13'd0; s.span = 13'd500; s.p0 = 10'd550; s.dp = -10'sd70;
            s.u0 = 7'd20; s.du = 7'sd8;
        end else if (r <= 13'd1000) begin
            s.r0 = 13'd500; s.span = 13'd500; s.p0 = 10'd480; s.dp = -10'sd80;
            s.u0 = 7'd28; s.du = 7'sd10;
        end else if (r <= 13'd2000) begin
            s.r0 = 13'd1000; s.span = 13'd1000; s.p0 = 10'd400; s.dp = -10'sd100;
            s.u0 = 7'd38; s.du = 7'sd17;
        end else if (r <= 13'd3000) begin
            s.r0 = 13'd2000; s.span = 13'd1000; s.p0 = 10'd300; s.dp = -10'sd70;
            s.u0 = 7'd55; s.du = 7'sd13;
        end else if (r <= 13'd4000) begin
            s.r0 = 13'd3000; s.span = 13'd1000; s.p0 = 10'd230; s.dp = -10'sd50;
            s.u0 = 7'd68; s.du = 7'sd10;
        end else if (r <= 13'd5000) begin
            s.r0 = 13'd4000; s.span = 13'd1000; s.p0 = 10'd180; s.dp = -10'sd40;
            s.u0 = 7'd78; s.du = 7'sd10;
        end else begin
            s.span = 13'd1000; s.p0 = 10'd140; s.u0 = 7'd88;
        end
        return s;
    endfunction

    function automatic seg_t sink_seg(input logic [12:0] r);
        seg_t s;
        s = '0;
        if (r == 13'd0) begin
            s.span = 13'd1000; s.p0 = 10'd400; s.u0 = 7'd35;
        end else if (r <= 13'd1000) begin
            s.r0 = 13'd0; s.span = 13'd1000; s.p0 = 10'd400; s.dp = -10'sd80;
            s.u0 = 7'd35; s.du = 7'sd10;
        end else if (r <= 13'd2000) begin
            s.r0 = 13'd1000; s.span = 13'd1000; s.p0 = 10'd320; s.dp = -10'sd60;
            s.u0 = 7'd45; s.du = 7'sd10;
        end else if (r <= 13'd4000) begin
            s.r0 = 13'd2000; s.span = 13'd2000; s.p0 = 10'd260; s.dp = -10'sd60;
            s.u0 = 7'd55; s.du = 7'sd13;
        end else if (r <= 13'd6000) begin
            s.r0 = 13'd4000; s.span = 13'd2000; s.p0 = 10'd200; s.dp = -10'sd40;
            s.u0 = 7'd68; s.du = 7'sd12;
        end else begin
            s.span = 13'd1000; s.p0 = 10'd160; s.u0 = 7'd80;
        end
        return s;
    endfunction

endpackage

>>> rtl/vbt_front.sv
// front part: register clamping, evaluation timing, mode tracking
module vbt_front
    import vbt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        now_ms,
    input  logic signed [15:0] vario_mms,
    input  logic [12:0]        climb_start,
    input  logic [12:0]        climb_stop,
    input  logic signed [13:0] sink_start,
    input  logic signed [13:0] sink_stop,
    input  logic               sink_en,
    output logic               q_valid,
    input  logic               q_ready,
    output item_t              q_item
);

    logic [TIME_BITS-1:0] last_eval_reg, last_eval_next;
    logic [1:0]           mode_reg, mode_next;
    logic [7:0]           ccnt_reg, ccnt_next, scnt_reg, scnt_next;

    logic [TIME_BITS-1:0] now_t, diff_t;
    logic                 due;
    logic signed [17:0]   v, cs, cst, ss, sst;
    logic                 ch;
    logic [12:0]          rate;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;

    // clamped thresholds and evaluation timing
    always_comb begin
        v   = 18'(vario_mms);
        cs  = 18'(signed'({1'b0, climb_start}));
        if (cs < 18'sd150) cs = 18'sd150;
        if (cs > 18'sd5000) cs = 18'sd5000;
        cst = 18'(signed'({1'b0, climb_stop}));
        if (cst > cs - 18'sd30) cst = cs - 18'sd30;
        if (cst < 18'sd50) cst = 18'sd50;
        ss  = 18'(sink_start);
        if (ss < -18'sd8000) ss = -18'sd8000;
        if (ss > -18'sd400) ss = -18'sd400;
        sst = 18'(sink_stop);
        if (sst > -18'sd10) sst = -18'sd10;
        if (sst < ss) sst = ss;
        now_t  = TIME_BITS'(now_ms);
        diff_t = now_t - last_eval_reg;
        due    = diff_t >= TIME_BITS'(EVAL_MS);
    end

    // mode and entry counters
    always_comb begin
        last_eval_next = due ? now_t : last_eval_reg;
        mode_next = mode_reg;
        ccnt_next = ccnt_reg;
        scnt_next = scnt_reg;
        unique case (mode_reg)
            MODE_SILENT: begin
                if (due) begin
                    if (v >= cs) ccnt_next = (ccnt_reg == 8'hFF) ? ccnt_reg : ccnt_reg + 8'd1;
                    else ccnt_next = '0;
                    if (sink_en && v <= ss)
                        scnt_next = (scnt_reg == 8'hFF) ? scnt_reg : scnt_reg + 8'd1;
                    else scnt_next = '0;
                    if (ccnt_next >= 8'(ENTER_SAMPLES)) mode_next = MODE_CLIMB;
                    else if (scnt_next >= 8'(ENTER_SAMPLES)) mode_next = MODE_SINK;
                end
            end
            MODE_CLIMB: if (v <= cst) mode_next = MODE_SILENT;
            default:    if (v >= sst) mode_next = MODE_SILENT;
        endcase
        ch = mode_next != mode_reg;
        if (ch) begin
            ccnt_next = '0;
            scnt_next = '0;
        end
    end

    // rate magnitude for the tone and cadence
    always_comb begin
        rate = '0;
        if (mode_next == MODE_CLIMB) begin
            if (v > 18'sd8000) rate = 13'd8000;
            else if (v > 18'sd0) rate = v[12:0];
        end else begin
            if (v < -18'sd8000) rate = 13'd8000;
            else if (v < 18'sd0) rate = 13'(-v);
        end
        q_item.mode    = mode_next;
        q_item.changed = ch;
        q_item.rate    = rate;
        q_item.now     = now_ms;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_eval_reg <= '0;
            mode_reg      <= MODE_SILENT;
            ccnt_reg      <= '0;
            scnt_reg      <= '0;
        end else if (in_valid && q_ready) begin
            last_eval_reg <= last_eval_next;
            mode_reg      <= mode_next;
            ccnt_reg      <= ccnt_next;
            scnt_reg      <= scnt_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != 2'd3)
        else $error("front mode register holds an unused code");
    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_SILENT |-> ccnt_reg == 8'd0 && scnt_reg == 8'd0)
        else $error("entry counters not cleared in an active mode");

endmodule

>>> rtl/vbt_queue.sv
// two-entry queue between front and back parts
module vbt_queue
    import vbt_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr_en, rd_en;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_item  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_item;
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue overfilled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 || cnt_reg == 2'd2 |-> wp_reg == rp_reg)
        else $error("queue pointers disagree with fill count");

endmodule

>>> rtl/vbt_back.sv
// back part: beep scheduler with tone and cadence computation
module vbt_back
    import vbt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    input  logic [11:0] climb_base,
    input  logic [9:0]  climb_gain,
    input  logic [10:0] sink_base,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tone_on,
    output logic [13:0] tone_freq,
    output logic [1:0]  tone_mode
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_ON   = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    // rounded-up reciprocals of the constant divisors
    localparam logic [19:0] RECIP_125    = 20'd536871;     // 2^26 / 125
    localparam logic [20:0] RECIP_125_F  = 21'd1073742;    // 2^27 / 125
    localparam logic [29:0] RECIP_390625 = 30'd720575941;  // 2^48 / 390625

    state_t               state_reg, state_next;
    item_t                it_reg;
    logic [TIME_BITS-1:0] next_beep_reg, beep_stop_reg;
    logic                 run_reg;
    logic [13:0]          freq_reg;
    logic                 o_on_reg;
    logic [13:0]          o_freq_reg;
    logic [1:0]           o_mode_reg;

    // cadence datapath registers
    seg_t                 seg_reg;
    logic [19:0]          pn_reg;     // P = p0*D + dp*d, always positive
    logic [17:0]          un_reg;     // U = u0*D + du*d
    logic [19:0]          fq_reg;     // rate*gain / 8, or rate*SINK_SLOPE / 8 in sink mode
    logic [37:0]          pu_reg;     // P*U
    logic [13:0]          quo_reg;    // rate*gain / 1000, or rate*SINK_SLOPE / 1000 in sink mode
    logic [13:0]          fcalc_reg;
    logic [9:0]           per_reg;
    logic [9:0]           on_reg;

    logic [TIME_BITS-1:0] now_t;
    logic                 start;
    seg_t                 seg_c;
    logic signed [24:0]   pn_c;
    logic signed [18:0]   un_c;
    logic [22:0]          fprod;
    logic [11:0]          cb;
    logic [9:0]           cg;
    logic [10:0]          sb;
    logic [17:0]          per_x;
    logic [27:0]          on_x;
    logic [37:0]          per_prod;
    logic [57:0]          on_prod;
    logic [40:0]          quo_prod;

    assign now_t   = TIME_BITS'(it_reg.now);
    assign q_ready = state_reg == ST_IDLE && !out_valid;
    assign start   = it_reg.mode != MODE_SILENT &&
                     (it_reg.changed || (!run_reg && now_t >= next_beep_reg));

    // clamped tone registers, segment lookup and products
    always_comb begin
        cb = climb_base;
        if (cb < 12'd400) cb = 12'd400;
        if (cb > 12'd2500) cb = 12'd2500;
        cg = climb_gain;
        if (cg < 10'd50) cg = 10'd50;
        if (cg > 10'd1000) cg = 10'd1000;
        sb = sink_base;
        if (sb < 11'd150) sb = 11'd150;
        if (sb > 11'd1200) sb = 11'd1200;
        seg_c = (it_reg.mode == MODE_CLIMB) ? climb_seg(it_reg.rate) : sink_seg(it_reg.rate);
        pn_c  = 25'(signed'({1'b0, seg_c.p0})) * 25'(signed'({1'b0, seg_c.span}))
              + 25'(seg_c.dp) * 25'(signed'({1'b0, it_reg.rate - seg_c.r0}));
        un_c  = 19'(signed'({1'b0, seg_c.u0})) * 19'(signed'({1'b0, seg_c.span}))
              + 19'(seg_c.du) * 19'(signed'({1'b0, it_reg.rate - seg_c.r0}));
        fprod = (it_reg.mode == MODE_CLIMB) ? 23'(it_reg.rate) * 23'(cg)
                                             : 23'(it_reg.rate) * 23'(SINK_SLOPE);
    end

    // span 500/1000/2000 is 125 times a power of two, and span squared times 100 is 390625 times one
    always_comb begin
        unique case (seg_reg.span)
            13'd500: begin
                per_x = 18'(pn_reg >> 2);
                on_x  = 28'(pu_reg >> 6);
            end
            13'd2000: begin
                per_x = 18'(pn_reg >> 4);
                on_x  = 28'(pu_reg >> 10);
            end
            default: begin
                per_x = 18'(pn_reg >> 3);
                on_x  = 28'(pu_reg >> 8);
            end
        endcase
        per_prod = 38'(per_x) * 38'(RECIP_125);
        on_prod  = 58'(on_x) * 58'(RECIP_390625);
        quo_prod = 41'(fq_reg) * 41'(RECIP_125_F);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid && q_ready) state_next = ST_MUL;
            ST_MUL:  state_next = start ? ST_DIV : ST_FIN;
            ST_DIV:  state_next = ST_ON;
            ST_ON:   state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // datapath: products, then reciprocal multiplies for period, on time and tone
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: if (q_valid && q_ready) it_reg <= q_item;
            ST_MUL: begin
                seg_reg <= seg_c;
                pn_reg  <= pn_c[19:0];
                un_reg  <= un_c[17:0];
                fq_reg  <= fprod[22:3];
            end
            ST_DIV: begin
                pu_reg  <= 38'(pn_reg) * 38'(un_reg);
                per_reg <= per_prod[35:26];
                quo_reg <= quo_prod[40:27];
            end
            ST_ON: begin
                on_reg <= on_prod[57:48];
                if (it_reg.mode == MODE_CLIMB)
                    fcalc_reg <= 14'(cb) + quo_reg;
                else if (quo_reg + 14'(SINK_FLOOR) > 14'(sb))
                    fcalc_reg <= 14'(SINK_FLOOR);
                else
                    fcalc_reg <= 14'(sb) - quo_reg;
            end
            default: ;
        endcase
    end

    // beep state update and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_beep_reg <= '0;
            beep_stop_reg <= '0;
            run_reg       <= 1'b0;
            freq_reg      <= '0;
            out_valid     <= 1'b0;
        end else begin
            if (out_valid && out_ready) out_valid <= 1'b0;
            if (state_reg == ST_FIN) begin
                logic                 run_n;
                logic [TIME_BITS-1:0] stop_n, nxt_n;
                logic [13:0]          f_n;
                run_n  = it_reg.changed ? 1'b0 : run_reg;
                stop_n = it_reg.changed ? '0 : beep_stop_reg;
                nxt_n  = it_reg.changed ? '0 : next_beep_reg;
                f_n    = it_reg.changed ? '0 : freq_reg;
                if (it_reg.mode == MODE_SILENT) begin
                    run_n = 1'b0;
                    f_n   = '0;
                end else begin
                    if (!run_n && now_t >= nxt_n) begin
                        run_n  = 1'b1;
                        f_n    = fcalc_reg;
                        stop_n = now_t + TIME_BITS'(on_reg);
                        nxt_n  = now_t + TIME_BITS'(per_reg);
                    end
                    if (run_n && now_t >= stop_n) run_n = 1'b0;
                end
                run_reg       <= run_n;
                freq_reg      <= f_n;
                beep_stop_reg <= stop_n;
                next_beep_reg <= nxt_n;
                o_on_reg      <= run_n;
                o_freq_reg    <= f_n;
                o_mode_reg    <= it_reg.mode;
                out_valid     <= 1'b1;
            end
        end
    end

    assign tone_on   = o_on_reg;
    assign tone_freq = o_freq_reg;
    assign tone_mode = o_mode_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("back state not one-hot");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && tone_mode == MODE_SILENT |-> !tone_on && tone_freq == '0)
        else $error("tone active in silent mode");

endmodule

>>> rtl/vario_beep_tone_controller.sv
// top level of the vario beep tone controller
//  channel | direction | handshake         | payload
//  s_      | in        | s_tvalid/s_tready | tdata: now_ms[31:0], vario_mms[47:32]
//  m_      | out       | m_tvalid/m_tready | tdata: tone_on[0], tone_freq_hz[14:1],
//          |           |                   |        tone_mode[16:15]
//  cfg     | in        | cfg_wr_en         | cfg_index, cfg_wdata
// the back part steps each item through its idle, multiply, finish and output states, and
// when a beep starts also through the divide and on states for the reciprocal multiplies
// while m_tready stays low with a result waiting, the back part takes no new item
// reset is synchronous, active low; configuration registers reset to their default values
// a two-entry queue lets the front accept while the back works or m_ stalls
module vario_beep_tone_controller
    import vbt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // now_ms, vario_mms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // tone_on, tone_freq_hz, tone_mode, zero fill
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_wdata
);

    logic [12:0] climb_start_reg, climb_stop_reg;
    logic [13:0] sink_start_reg, sink_stop_reg;
    logic [11:0] climb_base_reg;
    logic [9:0]  climb_gain_reg;
    logic [10:0] sink_base_reg;
    logic        sink_en_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            climb_start_reg <= 13'd200;
            climb_stop_reg  <= 13'd80;
            sink_start_reg  <= -14'sd600;
            sink_stop_reg   <= -14'sd200;
            climb_base_reg  <= 12'd1100;
            climb_gain_reg  <= 10'd280;
            sink_base_reg   <= 11'd240;
            sink_en_reg     <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CLIMB_START: climb_start_reg <= cfg_wdata[12:0];
                REG_CLIMB_STOP:  climb_stop_reg  <= cfg_wdata[12:0];
                REG_SINK_START:  sink_start_reg  <= cfg_wdata;
                REG_SINK_STOP:   sink_stop_reg   <= cfg_wdata;
                REG_CLIMB_BASE:  climb_base_reg  <= cfg_wdata[11:0];
                REG_CLIMB_GAIN:  climb_gain_reg  <= cfg_wdata[9:0];
                REG_SINK_BASE:   sink_base_reg   <= cfg_wdata[10:0];
                REG_SINK_EN:     sink_en_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic  fq_valid, fq_ready, qb_valid, qb_ready;
    item_t fq_item, qb_item;
    logic        t_on;
    logic [13:0] t_freq;
    logic [1:0]  t_mode;

    vbt_front #(.TIME_BITS(TIME_BITS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .now_ms(s_tdata[31:0]), .vario_mms(s_tdata[47:32]),
        .climb_start(climb_start_reg), .climb_stop(climb_stop_reg),
        .sink_start(sink_start_reg), .sink_stop(sink_stop_reg),
        .sink_en(sink_en_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
    );

    vbt_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_item(qb_item)
    );

    vbt_back #(.TIME_BITS(TIME_BITS)) u_back (
        .aclk, .aresetn,
        .q_valid(qb_valid), .q_ready(qb_ready), .q_item(qb_item),
        .climb_base(climb_base_reg), .climb_gain(climb_gain_reg),
        .sink_base(sink_base_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .tone_on(t_on), .tone_freq(t_freq), .tone_mode(t_mode)
    );

    assign m_tdata = {7'd0, t_mode, t_freq, t_on};

endmodule
